// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is held.
`define ASSERT_CLKD(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked property, checked during reset as well.
`define ASSERT_CLKD_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/ptsl_pkg.sv -----
// Package for the pan/tilt slew limiter: types, codes and widths.
`timescale 1ns / 1ps
package ptsl_pkg;

    localparam int ANGLE_BITS_DEF = 8;
    localparam int CFG_W          = 8;
    localparam int CFG_IDX_W      = 3;
    localparam int VALUE_W        = 9;
    localparam int FUNC_W         = 2;
    localparam int S_TDATA_W      = 24;

    localparam logic [CFG_W-1:0] STEP_RST = 8'd1;
    localparam logic [CFG_W-1:0] MIN_RST  = 8'd0;
    localparam logic [CFG_W-1:0] MAX_RST  = 8'd180;
    localparam logic [CFG_W-1:0] HOME_RST = 8'd90;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK = 2'd0,
        FUNC_SET  = 2'd1,
        FUNC_REL  = 2'd2,
        FUNC_HOME = 2'd3
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STEP      = 3'd0,
        REG_MIN       = 3'd1,
        REG_MAX       = 3'd2,
        REG_HOME_PAN  = 3'd3,
        REG_HOME_TILT = 3'd4
    } reg_idx_t;

    // Limits shared by both axes
    typedef struct packed {
        logic [CFG_W-1:0] step_size;
        logic [CFG_W-1:0] min_angle;
        logic [CFG_W-1:0] max_angle;
    } limits_t;

endpackage

// ----- hw/rtl/ptsl_axis.sv -----
// Next position and goal of one axis for one command or tick.
`timescale 1ns / 1ps
module ptsl_axis #(
    parameter int ANGLE_BITS = ptsl_pkg::ANGLE_BITS_DEF
) (
    input  ptsl_pkg::func_t                  func,
    input  logic signed [ptsl_pkg::VALUE_W-1:0] value,
    input  logic                             enable,
    input  logic                             smooth,
    input  ptsl_pkg::limits_t                lim,
    input  logic [ptsl_pkg::CFG_W-1:0]       home,
    input  logic [ANGLE_BITS-1:0]            pos,
    input  logic [ANGLE_BITS-1:0]            goal,
    output logic [ANGLE_BITS-1:0]            pos_next,
    output logic [ANGLE_BITS-1:0]            goal_next
);
    import ptsl_pkg::*;

    localparam int SUM_W = ANGLE_BITS + 2;

    logic signed [SUM_W-1:0]  abs_val;
    logic signed [SUM_W-1:0]  rel_val;
    logic signed [SUM_W-1:0]  home_val;
    logic signed [SUM_W-1:0]  min_val;
    logic signed [SUM_W-1:0]  max_val;
    logic [ANGLE_BITS:0]      up_sum;
    logic [ANGLE_BITS-1:0]    down_gap;
    logic [ANGLE_BITS-1:0]    step_ext;
    logic [ANGLE_BITS-1:0]    slewed;
    logic [ANGLE_BITS-1:0]    abs_clamped;

    // below min wins over above max
    function automatic logic [ANGLE_BITS-1:0] clamp_f(
        input logic signed [SUM_W-1:0] a,
        input logic signed [SUM_W-1:0] lo,
        input logic signed [SUM_W-1:0] hi
    );
        logic [ANGLE_BITS-1:0] r;
        if (a < lo) begin
            r = lo[ANGLE_BITS-1:0];
        end else if (a > hi) begin
            r = hi[ANGLE_BITS-1:0];
        end else begin
            r = a[ANGLE_BITS-1:0];
        end
        return r;
    endfunction

    assign abs_val  = {{(SUM_W-VALUE_W){value[VALUE_W-1]}}, value};
    assign rel_val  = $signed({2'b00, goal}) + abs_val;
    assign home_val = $signed({{(SUM_W-CFG_W){1'b0}}, home});
    assign min_val  = $signed({{(SUM_W-CFG_W){1'b0}}, lim.min_angle});
    assign max_val  = $signed({{(SUM_W-CFG_W){1'b0}}, lim.max_angle});

    assign step_ext    = ANGLE_BITS'(lim.step_size);
    assign up_sum      = {1'b0, pos} + {1'b0, step_ext};
    assign down_gap    = pos - goal;
    assign abs_clamped = clamp_f(abs_val, min_val, max_val);

    always_comb begin
        if (pos < goal) begin
            slewed = (up_sum > {1'b0, goal}) ? goal : up_sum[ANGLE_BITS-1:0];
        end else if (pos > goal) begin
            slewed = (down_gap < step_ext) ? goal : pos - step_ext;
        end else begin
            slewed = pos;
        end
    end

    always_comb begin
        pos_next  = pos;
        goal_next = goal;
        case (func)
            FUNC_TICK: begin
                pos_next = slewed;
            end
            FUNC_SET: begin
                if (enable) begin
                    goal_next = abs_clamped;
                    if (!smooth) begin
                        pos_next = abs_clamped;
                    end
                end
            end
            FUNC_REL: begin
                goal_next = clamp_f(rel_val, min_val, max_val);
            end
            FUNC_HOME: begin
                goal_next = clamp_f(home_val, min_val, max_val);
            end
            default: begin
                pos_next  = pos;
                goal_next = goal;
            end
        endcase
    end

endmodule

// ----- hw/rtl/pan_tilt_slew_limiter_unit.sv -----
// Top level of the two-axis pan/tilt servo slew limiter.
//
//  channel  | direction | handshake                 | payload
//  s_       | in        | s_tvalid / s_tready       | s_tuser func, s_tdata values and flags
//  m_       | out       | m_tvalid / m_tready       | m_tdata angles and moving flag
//  cfg_     | in        | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// One item per cycle sustained while m_tready is high; results pass through the
// input register, then the result register.
// Synchronous active-low reset: positions and goals return to 90, registers
// to their defaults, both stages empty. cfg_ready is always high.
// A stalled m_ side holds the result; s_ keeps taking transfers until both
// stages are full.
`timescale 1ns / 1ps
module pan_tilt_slew_limiter_unit #(
    parameter int ANGLE_BITS = ptsl_pkg::ANGLE_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [8:0] pan_value, [17:9] tilt_value, [18] pan_enable, [19] tilt_enable,
    // [20] smooth, [23:21] zero
    input  logic [ptsl_pkg::S_TDATA_W-1:0]      s_tdata,
    // [1:0] func
    input  logic [ptsl_pkg::FUNC_W-1:0]         s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // pan_angle, tilt_angle, moving from bit 0 up, zero fill to whole bytes
    output logic [((2*ANGLE_BITS+8)/8)*8-1:0]   m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ptsl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ptsl_pkg::CFG_W-1:0]          cfg_data
);
    import ptsl_pkg::*;

    localparam int M_TDATA_W = ((2*ANGLE_BITS+8)/8)*8;

    limits_t                 lim_reg;
    logic [CFG_W-1:0]        home_pan_reg;
    logic [CFG_W-1:0]        home_tilt_reg;

    logic                    in_valid_reg;
    func_t                   func_reg;
    logic [S_TDATA_W-1:0]    in_data_reg;

    logic [ANGLE_BITS-1:0]   pan_pos_reg, tilt_pos_reg, pan_goal_reg, tilt_goal_reg;
    logic [ANGLE_BITS-1:0]   pan_pos_next, tilt_pos_next, pan_goal_next, tilt_goal_next;

    logic                    m_valid_reg;
    logic [M_TDATA_W-1:0]    m_data_reg;
    logic [M_TDATA_W-1:0]    m_data_next;
    logic                    moving;

    logic                    out_free;
    logic                    advance;

    assign out_free  = !m_valid_reg || m_tready;
    assign advance   = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lim_reg.step_size <= STEP_RST;
            lim_reg.min_angle <= MIN_RST;
            lim_reg.max_angle <= MAX_RST;
            home_pan_reg      <= HOME_RST;
            home_tilt_reg     <= HOME_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (reg_idx_t'(cfg_index))
                REG_STEP:      lim_reg.step_size <= cfg_data;
                REG_MIN:       lim_reg.min_angle <= cfg_data;
                REG_MAX:       lim_reg.max_angle <= cfg_data;
                REG_HOME_PAN:  home_pan_reg      <= cfg_data;
                REG_HOME_TILT: home_tilt_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            func_reg    <= func_t'(s_tuser);
            in_data_reg <= s_tdata;
        end
    end

    ptsl_axis #(.ANGLE_BITS(ANGLE_BITS)) u_pan (
        .func      (func_reg),
        .value     ($signed(in_data_reg[8:0])),
        .enable    (in_data_reg[18]),
        .smooth    (in_data_reg[20]),
        .lim       (lim_reg),
        .home      (home_pan_reg),
        .pos       (pan_pos_reg),
        .goal      (pan_goal_reg),
        .pos_next  (pan_pos_next),
        .goal_next (pan_goal_next)
    );

    ptsl_axis #(.ANGLE_BITS(ANGLE_BITS)) u_tilt (
        .func      (func_reg),
        .value     ($signed(in_data_reg[17:9])),
        .enable    (in_data_reg[19]),
        .smooth    (in_data_reg[20]),
        .lim       (lim_reg),
        .home      (home_tilt_reg),
        .pos       (tilt_pos_reg),
        .goal      (tilt_goal_reg),
        .pos_next  (tilt_pos_next),
        .goal_next (tilt_goal_next)
    );

    assign moving      = (pan_pos_next != pan_goal_next) || (tilt_pos_next != tilt_goal_next);
    assign m_data_next = M_TDATA_W'({moving, tilt_pos_next, pan_pos_next});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pan_pos_reg   <= ANGLE_BITS'(HOME_RST);
            pan_goal_reg  <= ANGLE_BITS'(HOME_RST);
            tilt_pos_reg  <= ANGLE_BITS'(HOME_RST);
            tilt_goal_reg <= ANGLE_BITS'(HOME_RST);
            m_valid_reg   <= 1'b0;
        end else begin
            if (advance) begin
                pan_pos_reg   <= pan_pos_next;
                pan_goal_reg  <= pan_goal_next;
                tilt_pos_reg  <= tilt_pos_next;
                tilt_goal_reg <= tilt_goal_next;
            end
            if (out_free) begin
                m_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

// ----- hw/rtl/ptsl_checker.sv -----
// Port-level checks of the slew limiter, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ptsl_checker #(
    parameter int ANGLE_BITS = ptsl_pkg::ANGLE_BITS_DEF
) (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [((2*ANGLE_BITS+8)/8)*8-1:0]   m_tdata
);

    `ASSERT_CLKD(a_m_hold_valid, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid, "m_tvalid dropped while stalled")
    `ASSERT_CLKD(a_m_hold_data, aclk, aresetn, m_tvalid && !m_tready |=> $stable(m_tdata), "m_tdata changed while stalled")
    `ASSERT_CLKD_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "result valid straight after reset")
    `ASSERT_CLKD(a_in_to_out, aclk, aresetn, s_tvalid && s_tready |-> ##2 m_tvalid, "accepted transfer produced no result")

endmodule

bind pan_tilt_slew_limiter_unit ptsl_checker #(.ANGLE_BITS(ANGLE_BITS)) u_ptsl_checker (.*);
